@@ hw/rtl/rpbd_pkg.sv @@
`timescale 1ns / 1ps

package rpbd_pkg;

    // Default grid size
    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 256;

    // Field and state widths
    localparam int BYTE_W = 8;
    localparam int COL_W  = 9;
    localparam int LINE_W = 12;
    localparam int CNT_W  = 12;
    localparam int LEN_W  = 9;
    localparam int POS_W  = 8;
    localparam int CFG_W  = 9;
    localparam int IDX_W  = 1;
    // Offsets and sums against a grid of up to 4096 cells
    localparam int CALC_W = 13;
    // Count times ten plus a digit
    localparam int PROD_W = 16;

    localparam logic [CNT_W-1:0]  COUNT_MAX = 12'd4095;
    localparam logic [LINE_W-1:0] LINE_MAX  = 12'd4095;
    localparam logic [COL_W-1:0]  COL_MAX   = 9'd511;

    // Body characters
    localparam logic [BYTE_W-1:0] CHAR_END  = 8'h21;  // '!'
    localparam logic [BYTE_W-1:0] CHAR_LIVE = 8'h6F;  // 'o'
    localparam logic [BYTE_W-1:0] CHAR_DEAD = 8'h62;  // 'b'
    localparam logic [BYTE_W-1:0] CHAR_EOL  = 8'h24;  // '$'
    localparam logic [BYTE_W-1:0] CHAR_0    = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CHAR_9    = 8'h39;  // '9'

    // Register indexes
    localparam logic [IDX_W-1:0] REG_PATTERN_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_PATTERN_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [LINE_W-1:0] line;
        logic [CNT_W-1:0]  pending;
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0] grid_row;
        logic [POS_W-1:0] grid_column;
        logic [LEN_W-1:0] run_length;
        logic             cell_alive;
        logic             pattern_end;
        logic             clipped;
    } result_t;

endpackage

@@ hw/rtl/rle_pattern_body_decoder_top.sv @@
`timescale 1ns / 1ps
// An accepted byte enters the byte register and its result the result register at m_*.
// Throughput: one byte per cycle while the result register is free or being taken;
// the step logic decides one byte per cycle, and digit bytes never wait on m_ready.
// Reset: aresetn (synchronous, active low) clears column, line and count, empties both
// registers and sets pattern width and height to 256.
module rle_pattern_body_decoder_top #(
    parameter int GRID_WIDTH  = rpbd_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = rpbd_pkg::GRID_HEIGHT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration writes
    input  logic                         cfg_wr_en,
    input  logic [rpbd_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rpbd_pkg::CFG_W-1:0]   cfg_data,
    // body byte requests
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rpbd_pkg::BYTE_W-1:0]  s_code_byte,
    // run requests
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rpbd_pkg::POS_W-1:0]   m_grid_row,
    output logic [rpbd_pkg::POS_W-1:0]   m_grid_column,
    output logic [rpbd_pkg::LEN_W-1:0]   m_run_length,
    output logic                         m_cell_alive,
    output logic                         m_pattern_end,
    output logic                         m_clipped
);

    // Configuration registers
    logic [rpbd_pkg::CFG_W-1:0] pattern_width_reg, pattern_width_next;
    logic [rpbd_pkg::CFG_W-1:0] pattern_height_reg, pattern_height_next;

    // Byte register in front of the step logic
    logic                        in_valid_reg, in_valid_next;
    logic [rpbd_pkg::BYTE_W-1:0] in_byte_reg, in_byte_next;

    // Decoder position and count
    rpbd_pkg::state_t state_reg, state_next, step_state;

    // Result register
    logic              out_valid_reg, out_valid_next;
    rpbd_pkg::result_t out_reg, out_next, step_result;

    logic step_emit;
    logic out_free;
    logic step_go;

    rpbd_step #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_step (
        .code_byte      (in_byte_reg),
        .state          (state_reg),
        .pattern_width  (pattern_width_reg),
        .pattern_height (pattern_height_reg),
        .state_next     (step_state),
        .emit           (step_emit),
        .result         (step_result)
    );

    // The result slot frees up when its request is taken this cycle
    assign out_free = !out_valid_reg || m_ready;
    // Retire the held byte unless it has a result and the slot is still full
    assign step_go  = in_valid_reg && (!step_emit || out_free);
    assign s_ready  = !in_valid_reg || step_go;

    always_comb begin
        pattern_width_next  = pattern_width_reg;
        pattern_height_next = pattern_height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                rpbd_pkg::REG_PATTERN_WIDTH:  pattern_width_next  = cfg_data;
                rpbd_pkg::REG_PATTERN_HEIGHT: pattern_height_next = cfg_data;
                default: ;
            endcase
        end

        // Load a new byte or drop the retired one
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_byte_next  = s_code_byte;
        end

        // Advance position and count only when the byte retires
        state_next = step_go ? step_state : state_reg;

        // Hold the result until taken, then refill from the step logic
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        if (step_go && step_emit) begin
            out_valid_next = 1'b1;
            out_next       = step_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_width_reg  <= rpbd_pkg::CFG_W'(256);
            pattern_height_reg <= rpbd_pkg::CFG_W'(256);
            in_valid_reg       <= 1'b0;
            state_reg          <= '0;
            out_valid_reg      <= 1'b0;
        end else begin
            pattern_width_reg  <= pattern_width_next;
            pattern_height_reg <= pattern_height_next;
            in_valid_reg       <= in_valid_next;
            state_reg          <= state_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_grid_row    = out_reg.grid_row;
    assign m_grid_column = out_reg.grid_column;
    assign m_run_length  = out_reg.run_length;
    assign m_cell_alive  = out_reg.cell_alive;
    assign m_pattern_end = out_reg.pattern_end;
    assign m_clipped     = out_reg.clipped;

endmodule

@@ hw/rtl/rpbd_step.sv @@
`timescale 1ns / 1ps

module rpbd_step #(
    parameter int GRID_WIDTH  = rpbd_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = rpbd_pkg::GRID_HEIGHT_DEF
) (
    input  logic [rpbd_pkg::BYTE_W-1:0] code_byte,
    input  rpbd_pkg::state_t            state,
    input  logic [rpbd_pkg::CFG_W-1:0]  pattern_width,
    input  logic [rpbd_pkg::CFG_W-1:0]  pattern_height,
    output rpbd_pkg::state_t            state_next,
    output logic                        emit,
    output rpbd_pkg::result_t           result
);

    localparam int CW     = rpbd_pkg::CALC_W;
    localparam int COL_W  = rpbd_pkg::COL_W;
    localparam int LINE_W = rpbd_pkg::LINE_W;
    localparam int CNT_W  = rpbd_pkg::CNT_W;
    localparam int LEN_W  = rpbd_pkg::LEN_W;
    localparam int PROD_W = rpbd_pkg::PROD_W;
    localparam int POS_W  = rpbd_pkg::POS_W;
    localparam logic [CW-1:0] GW = CW'(GRID_WIDTH);
    localparam logic [CW-1:0] GH = CW'(GRID_HEIGHT);

    logic [CW-1:0]     pw_ext, ph_ext, w_ext, h_ext, dx, dy;
    logic [COL_W-1:0]  w, col, colm, avail, fill;
    logic [CNT_W-1:0]  n;
    logic              line_in;
    logic [3:0]        digit;
    logic [PROD_W-1:0] prod;
    logic [CW-1:0]     col_plus_n, line_plus_n, row_sum, col_sum;
    logic [LEN_W-1:0]  kept;
    logic [COL_W-1:0]  run_col;

    always_comb begin
        pw_ext = CW'(pattern_width);
        ph_ext = CW'(pattern_height);
        w_ext  = (pw_ext > GW) ? GW : pw_ext;
        h_ext  = (ph_ext > GH) ? GH : ph_ext;
        w      = w_ext[COL_W-1:0];
        dx     = (GW - w_ext) >> 1;
        dy     = (GH - h_ext) >> 1;
        n      = (state.pending == '0) ? CNT_W'(1) : state.pending;
        line_in = CW'(state.line) < h_ext;
        col    = state.column;
        colm   = (col < w) ? col : w;
        avail  = w - col;
        fill   = w - colm;
        digit  = 4'(code_byte - rpbd_pkg::CHAR_0);
        prod   = PROD_W'(state.pending) * PROD_W'(10) + PROD_W'(digit);
        col_plus_n  = CW'(col) + CW'(n);
        line_plus_n = CW'(state.line) + CW'(n);

        state_next = state;
        emit       = 1'b0;
        kept       = '0;
        run_col    = col;
        result     = '0;

        if (code_byte >= rpbd_pkg::CHAR_0 && code_byte <= rpbd_pkg::CHAR_9) begin
            state_next.pending = (prod > PROD_W'(rpbd_pkg::COUNT_MAX)) ?
                                 rpbd_pkg::COUNT_MAX : prod[CNT_W-1:0];
        end else if (code_byte == rpbd_pkg::CHAR_LIVE || code_byte == rpbd_pkg::CHAR_DEAD) begin
            emit = 1'b1;
            if (line_in && col < w) begin
                kept = (n < CNT_W'(avail)) ? n[LEN_W-1:0] : LEN_W'(avail);
            end
            result.cell_alive = (code_byte == rpbd_pkg::CHAR_LIVE);
            result.clipped    = CNT_W'(kept) < n;
            // A column already past a shrunk width only needs to stay past it
            if (col > w) begin
                state_next.column = (col_plus_n > CW'(rpbd_pkg::COL_MAX)) ?
                                    rpbd_pkg::COL_MAX : col_plus_n[COL_W-1:0];
            end else if (CNT_W'(avail) > n) begin
                state_next.column = col_plus_n[COL_W-1:0];
            end else begin
                state_next.column = w;
            end
            state_next.pending = '0;
        end else if (code_byte == rpbd_pkg::CHAR_EOL) begin
            emit    = 1'b1;
            run_col = colm;
            kept    = line_in ? LEN_W'(fill) : '0;
            result.clipped = !line_in && (fill != '0);
            state_next.column  = '0;
            state_next.line   = (line_plus_n > CW'(rpbd_pkg::LINE_MAX)) ?
                                rpbd_pkg::LINE_MAX : line_plus_n[LINE_W-1:0];
            state_next.pending = '0;
        end else if (code_byte == rpbd_pkg::CHAR_END) begin
            emit = 1'b1;
            result.pattern_end = 1'b1;
            state_next = '0;
        end

        row_sum = dy + CW'(state.line);
        col_sum = dx + CW'(run_col);
        result.run_length = kept;
        if (kept != '0) begin
            result.grid_row    = row_sum[POS_W-1:0];
            result.grid_column = col_sum[POS_W-1:0];
        end
    end

endmodule

@@ test/tb_rle_pattern_body_decoder_top.sv @@
`timescale 1ns / 1ps

module tb_rle_pattern_body_decoder_top;

    localparam int GRID_W          = 256;
    localparam int GRID_H          = 256;
    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 11;
    // Time to let the block settle after a drain, before a register write
    localparam int SETTLE_CYCLES   = 4;
    localparam int NUM_PHASES      = 6;
    localparam int BYTES_PER_PHASE = 330;
    // Watchdog limit on the length of the whole run
    localparam int CYCLE_LIMIT     = 400000;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [rpbd_pkg::IDX_W-1:0]   cfg_index;
    logic [rpbd_pkg::CFG_W-1:0]   cfg_data;
    logic                         s_valid;
    logic                         s_ready;
    logic [rpbd_pkg::BYTE_W-1:0]  s_code_byte;
    logic                         m_valid;
    logic                         m_ready;
    logic [rpbd_pkg::POS_W-1:0]   m_grid_row;
    logic [rpbd_pkg::POS_W-1:0]   m_grid_column;
    logic [rpbd_pkg::LEN_W-1:0]   m_run_length;
    logic                         m_cell_alive;
    logic                         m_pattern_end;
    logic                         m_clipped;

    // Body bytes waiting to be sent, and runs the decoder still owes us
    logic [rpbd_pkg::BYTE_W-1:0]  byte_queue[$];
    rpbd_pkg::result_t            expected_runs[$];
    rpbd_pkg::result_t            oldest_run;

    // Shadow of the decoder: registers and position state
    logic [rpbd_pkg::CFG_W-1:0]   width_reg  = 9'd256;
    logic [rpbd_pkg::CFG_W-1:0]   height_reg = 9'd256;
    logic [rpbd_pkg::COL_W-1:0]   col_pos    = '0;
    logic [rpbd_pkg::LINE_W-1:0]  line_pos   = '0;
    logic [rpbd_pkg::CNT_W-1:0]   pend_count = '0;

    int                 send_idle_pct  = 13;
    int                 recv_stall_pct = 68;
    bit                 byte_taken;
    int                 error_count = 0;
    int                 cycle_count = 0;

    rle_pattern_body_decoder_top #(
        .GRID_WIDTH (GRID_W),
        .GRID_HEIGHT(GRID_H)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code_byte  (s_code_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_grid_row   (m_grid_row),
        .m_grid_column(m_grid_column),
        .m_run_length (m_run_length),
        .m_cell_alive (m_cell_alive),
        .m_pattern_end(m_pattern_end),
        .m_clipped    (m_clipped)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        error_count++;
    endtask

    // Pack one run; an empty run carries no position
    function automatic rpbd_pkg::result_t make_run(input int row, input int col, input int len,
                                                   input bit alive, input bit fin,
                                                   input bit clip);
        rpbd_pkg::result_t r;
        if (len == 0) begin
            row = 0;
            col = 0;
        end
        r.grid_row    = rpbd_pkg::POS_W'(row);
        r.grid_column = rpbd_pkg::POS_W'(col);
        r.run_length  = rpbd_pkg::LEN_W'(len);
        r.cell_alive  = alive;
        r.pattern_end = fin;
        r.clipped     = clip;
        return r;
    endfunction

    // Advance the shadow decoder by one body byte and queue the run it owes
    task automatic decode_body_byte(input logic [rpbd_pkg::BYTE_W-1:0] code);
        int w, h, dx, dy, n, col, kept, fill, v;
        bit line_in;
        w  = (int'(width_reg) > GRID_W) ? GRID_W : int'(width_reg);
        h  = (int'(height_reg) > GRID_H) ? GRID_H : int'(height_reg);
        dx = (GRID_W - w) / 2;
        dy = (GRID_H - h) / 2;
        // A missing or zero count means one
        n  = (pend_count == '0) ? 1 : int'(pend_count);
        line_in = int'(line_pos) < h;
        if (code >= rpbd_pkg::CHAR_0 && code <= rpbd_pkg::CHAR_9) begin
            // Build the count, saturating on long digit strings
            v = int'(pend_count) * 10 + int'(code) - int'(rpbd_pkg::CHAR_0);
            pend_count = (v > int'(rpbd_pkg::COUNT_MAX)) ? rpbd_pkg::COUNT_MAX :
                                                           rpbd_pkg::CNT_W'(v);
        end else if (code == rpbd_pkg::CHAR_LIVE || code == rpbd_pkg::CHAR_DEAD) begin
            col  = int'(col_pos);
            kept = 0;
            if (line_in && col < w) begin
                kept = (n < w - col) ? n : w - col;
            end
            expected_runs.push_back(make_run(dy + int'(line_pos), dx + col, kept,
                                             code == rpbd_pkg::CHAR_LIVE, 1'b0, kept < n));
            // Hold the column at the pattern edge once a run reaches it; a column
            // already past a shrunk width keeps moving past it
            if (col > w) begin
                v = col + n;
                col_pos = (v > int'(rpbd_pkg::COL_MAX)) ? rpbd_pkg::COL_MAX :
                                                          rpbd_pkg::COL_W'(v);
            end else begin
                col_pos = ((w - col) > n) ? rpbd_pkg::COL_W'(col + n) : rpbd_pkg::COL_W'(w);
            end
            pend_count = '0;
        end else if (code == rpbd_pkg::CHAR_EOL) begin
            // Dead fill to the end of the line, always emitted
            col  = (int'(col_pos) < w) ? int'(col_pos) : w;
            fill = w - col;
            kept = line_in ? fill : 0;
            expected_runs.push_back(make_run(dy + int'(line_pos), dx + col, kept,
                                             1'b0, 1'b0, !line_in && fill > 0));
            col_pos    = '0;
            v          = int'(line_pos) + n;
            line_pos   = (v > int'(rpbd_pkg::LINE_MAX)) ? rpbd_pkg::LINE_MAX :
                                                          rpbd_pkg::LINE_W'(v);
            pend_count = '0;
        end else if (code == rpbd_pkg::CHAR_END) begin
            expected_runs.push_back(make_run(0, 0, 0, 1'b0, 1'b1, 1'b0));
            col_pos    = '0;
            line_pos   = '0;
            pend_count = '0;
        end
        // Any other byte leaves the state alone, pending count included
    endtask

    task automatic queue_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            byte_queue.push_back(text[i]);
        end
    endtask

    task automatic queue_count(input int value);
        queue_text($sformatf("%0d", value));
    endtask

    // One pattern body: mostly counted runs and line moves, some noise,
    // usually closed by the end marker
    task automatic queue_random_pattern(input int span);
        int tokens, pick;
        tokens = $urandom_range(40, 4);
        for (int t = 0; t < tokens; t++) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                byte_queue.push_back(rpbd_pkg::BYTE_W'($urandom_range(255)));
                continue;
            end
            pick = $urandom_range(99);
            if (pick < 5) begin
                queue_count(0);
            end else if (pick < 50) begin
                queue_count($urandom_range(span, 1));
            end else if (pick < 58) begin
                queue_count($urandom_range(99999, span));
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                byte_queue.push_back(rpbd_pkg::CHAR_LIVE);
            end else if (pick < 75) begin
                byte_queue.push_back(rpbd_pkg::CHAR_DEAD);
            end else begin
                byte_queue.push_back(rpbd_pkg::CHAR_EOL);
            end
        end
        if ($urandom_range(99) < 92) begin
            byte_queue.push_back(rpbd_pkg::CHAR_END);
        end
    endtask

    // Register writes only go in while the decoder is idle
    task automatic write_register(input logic [rpbd_pkg::IDX_W-1:0] index, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= rpbd_pkg::CFG_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == rpbd_pkg::REG_PATTERN_WIDTH) begin
            width_reg = rpbd_pkg::CFG_W'(value);
        end else begin
            height_reg = rpbd_pkg::CFG_W'(value);
        end
    endtask

    // Wait until every request is sent and every run is back, then let the
    // pipeline settle in case the last byte owed nothing
    task automatic wait_for_drain();
        @(posedge aclk);
        while (byte_queue.size() != 0 || s_valid || expected_runs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int w_eff, h_eff, span;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = rpbd_pkg::REG_PATTERN_WIDTH;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_code_byte = '0;
        m_ready     = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed body at the reset size: counted, bare and zero runs, line
        // moves, a saturating count that runs off the pattern edge, a count that
        // survives stray bytes, a line move far past the bottom, the end marker
        queue_text("3ob0o$2$99999b5");
        byte_queue.push_back(8'hFF);
        queue_text("o4096$o");
        byte_queue.push_back(8'h00);
        byte_queue.push_back(rpbd_pkg::CHAR_END);
        wait_for_drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin w_eff = 256; h_eff = 256; end
                1: begin w_eff = 1;   h_eff = 1;   end
                2: begin w_eff = 0;   h_eff = 0;   end
                3: begin w_eff = 511; h_eff = 300; end
                4: begin w_eff = $urandom_range(256, 1); h_eff = $urandom_range(256, 1); end
                default: begin w_eff = 20; h_eff = 7; end
            endcase
            write_register(rpbd_pkg::REG_PATTERN_WIDTH, w_eff);
            write_register(rpbd_pkg::REG_PATTERN_HEIGHT, h_eff);

            // Receiver sparse first, then sender sparse, then both at full rate
            if (p < 2) begin
                send_idle_pct  = 13;
                recv_stall_pct = 68;
            end else if (p < 4) begin
                send_idle_pct  = 68;
                recv_stall_pct = 13;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            // Counts range a little past the pattern so edges get hit often
            span = ((w_eff > h_eff) ? w_eff : h_eff);
            span = ((span > GRID_W) ? GRID_W : span) + 2;
            while (byte_queue.size() < BYTES_PER_PHASE) begin
                queue_random_pattern(span);
            end
            // Close the phase so the next size starts from a clean position
            byte_queue.push_back(rpbd_pkg::CHAR_END);
            wait_for_drain();
        end

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Byte driver: present a new request once the previous one is taken,
    // idling at random; hold the payload until the handshake completes
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || byte_taken) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid     <= 1'b1;
                s_code_byte <= byte_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Run receiver: stall at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check the run leaving first, then predict from the byte
    // entering, so both sides of one edge see a consistent queue
    always @(posedge aclk) begin
        byte_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_runs.size() == 0) begin
                    report_mismatch("run with none owed, length", m_run_length, 0);
                end else begin
                    oldest_run = expected_runs.pop_front();
                    if (m_grid_row !== oldest_run.grid_row)
                        report_mismatch("grid_row", m_grid_row, oldest_run.grid_row);
                    if (m_grid_column !== oldest_run.grid_column)
                        report_mismatch("grid_column", m_grid_column, oldest_run.grid_column);
                    if (m_run_length !== oldest_run.run_length)
                        report_mismatch("run_length", m_run_length, oldest_run.run_length);
                    if (m_cell_alive !== oldest_run.cell_alive)
                        report_mismatch("cell_alive", m_cell_alive, oldest_run.cell_alive);
                    if (m_pattern_end !== oldest_run.pattern_end)
                        report_mismatch("pattern_end", m_pattern_end, oldest_run.pattern_end);
                    if (m_clipped !== oldest_run.clipped)
                        report_mismatch("clipped", m_clipped, oldest_run.clipped);
                end
            end
            if (s_valid && s_ready) begin
                decode_body_byte(s_code_byte);
            end
        end
    end

    // Watchdog: drop the run if it hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
